@@ rtl/smf_pkg.sv @@
// Shared types and fixed constants of the streaming median filter.
// Holds the item, result and pipeline control structs and the register map.
// No dependencies; the core and smf_median refer to it by scoped names.
package smf_pkg;

  // Fixed field widths.
  localparam int PIX_W        = 8;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int ROW_W        = 12;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 12;

  // Register values after reset.
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // Item codes carried in the action field.
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // Output queue sizing.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // Configuration register map.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_in;
  } smf_item_t;

  // One result item.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } smf_result_t;

  // Control that travels alongside the window data through the pipeline.
  typedef struct packed {
    logic valid;
    logic emit;
    logic border;
    logic frame_end;
  } smf_ctrl_t;

endpackage

@@ rtl/streaming_median_filter_core.sv @@
// Top level of the streaming WINDOW x WINDOW median filter for 8-bit pixels.
// Depends on smf_pkg, smf_ram (history copies) and smf_median (rank select).
//
// Usage:
//   Pixels enter in raster order on the item channel (item_valid, item_stall,
//   item); a transfer takes place when item_valid is high and item_stall low.
//   A flush item (action set) pushes out one pending pixel once the input has
//   wrapped to the start of the next frame; elsewhere it yields nothing.
//   Results leave on the result channel (result_valid, result_stall, result);
//   frame_end marks the bottom-right pixel of each frame. Results trail the
//   input by RADIUS rows plus RADIUS pixels.
//   image_width and image_height are written through the cfg port, which is
//   always ready; write them while the block is idle.
// Timing:
//   One item is accepted per clock while item_stall is low. A result passes
//   the history RAM read, compare stage, rank stage and output queue after
//   the edge that accepts its item. All WINDOW*WINDOW history RAM copies are
//   read at once, so a new item is taken before the last is through. An
//   8-entry output queue absorbs a stalled receiver; item_stall rises once 8
//   items are in flight or waiting, and falls as results or dropped items leave.
// Reset: positions and counters clear, the registers return to 640 x 480;
//   the history RAMs are not cleared and no clearing pass runs.
module streaming_median_filter_core #(
  parameter int WINDOW    = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  smf_pkg::smf_item_t               item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output smf_pkg::smf_result_t             result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [smf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RADIUS = WINDOW / 2;
  localparam int TAPS   = WINDOW * WINDOW;
  localparam int RING   = WINDOW * MAX_WIDTH;
  localparam int AW     = $clog2(RING);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int PW     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
  localparam int SW     = AW + 2;
  localparam int XW     = (WW > smf_pkg::CFG_WIDTH_W) ? WW : smf_pkg::CFG_WIDTH_W;
  localparam int RW     = smf_pkg::ROW_W;

  // Configuration registers.
  logic [smf_pkg::CFG_WIDTH_W-1:0]  image_width;
  logic [smf_pkg::CFG_HEIGHT_W-1:0] image_height;

  // Stage 1: accepted item and stream position state.
  logic               valid1;
  smf_pkg::smf_item_t item1;
  logic [AW-1:0]      wp, wp_next;
  logic [AW-1:0]      ep, ep_next;
  logic [PW-1:0]      pending, pending_next;
  logic [CW-1:0]      in_col, in_col_next, out_col, out_col_next;
  logic [RW-1:0]      in_row, in_row_next, out_row, out_row_next;

  logic [XW-1:0]      width_ext;
  logic [WW-1:0]      eff_w;
  logic [RW-1:0]      eff_h;
  logic [PW-1:0]      lag;
  logic [PW:0]        pend_p1;
  logic [CW:0]        in_col_p1, out_col_p1;
  logic [RW:0]        in_row_p1, out_row_p1;
  logic               is_flush;
  logic               emit1;
  logic               wr_en;
  logic               border1;
  logic               frame_end1;
  smf_pkg::smf_ctrl_t ctrl1;

  logic [AW-1:0]      row_addr [WINDOW];
  logic [AW-1:0]      lane_waddr [WINDOW];

  // Stage 2: RAM read data and bypass of the pixel written in the same cycle.
  smf_pkg::smf_ctrl_t        ctrl2;
  logic [smf_pkg::PIX_W-1:0] ram_q [TAPS];
  logic                      hit_c [TAPS];
  logic                      byp_hit [TAPS];
  logic [smf_pkg::PIX_W-1:0] byp_pix;
  logic [smf_pkg::PIX_W-1:0] taps2 [TAPS];

  // Rank selector outputs.
  smf_pkg::smf_ctrl_t        med_ctrl;
  logic [smf_pkg::PIX_W-1:0] med_pix;

  // Output queue and credit count.
  smf_pkg::smf_result_t           fifo_mem [smf_pkg::FIFO_DEPTH];
  logic [smf_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [smf_pkg::FIFO_CNT_W-1:0] fifo_cnt, fifo_cnt_next;
  logic [smf_pkg::FIFO_CNT_W-1:0] credit, credit_next;
  logic                           accept;
  logic                           push;
  logic                           pop;
  logic                           drop;

  // Configuration port: writes land at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= smf_pkg::WIDTH_RESET;
      image_height <= smf_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (smf_pkg::cfg_reg_t'(cfg_index))
        smf_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[smf_pkg::CFG_WIDTH_W-1:0];
        end
        smf_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[smf_pkg::CFG_HEIGHT_W-1:0];
        end
      endcase
    end
  end

  // Input handshake; the pipeline itself never stalls.
  assign accept     = item_valid && !item_stall;
  assign item_stall = (credit >= smf_pkg::FIFO_CNT_W'(smf_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
    if (accept) begin
      item1 <= item;
    end
  end

  // Effective frame size, with out-of-range register values clamped.
  always_comb begin
    width_ext = XW'(image_width);
    if (width_ext == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_ext);
    end
    eff_h = (image_height == '0) ? RW'(1) : image_height;
    lag   = PW'(eff_w) * PW'(RADIUS) + PW'(RADIUS);
  end

  // Stage 1 decisions: store the pixel, decide whether a result is due and
  // classify the output position.
  always_comb begin
    is_flush   = (item1.action == smf_pkg::ACTION_FLUSH);
    pend_p1    = {1'b0, pending} + (PW + 1)'(1);
    in_col_p1  = {1'b0, in_col} + (CW + 1)'(1);
    in_row_p1  = {1'b0, in_row} + (RW + 1)'(1);
    out_col_p1 = {1'b0, out_col} + (CW + 1)'(1);
    out_row_p1 = {1'b0, out_row} + (RW + 1)'(1);

    if (is_flush) begin
      emit1 = valid1 && (in_row == '0) && (in_col == '0) && (pending != '0);
    end else begin
      emit1 = valid1 && (pend_p1 > {1'b0, lag});
    end
    wr_en = valid1 && !is_flush;

    border1 = (out_col < CW'(RADIUS)) || (out_row < RW'(RADIUS)) ||
              (({2'b00, out_col} + (CW + 2)'(RADIUS)) >= (CW + 2)'(eff_w)) ||
              (({2'b00, out_row} + (RW + 2)'(RADIUS)) >= {2'b00, eff_h});
    frame_end1 = (out_row_p1 >= {1'b0, eff_h}) && (out_col_p1 >= eff_w);

    ctrl1.valid     = valid1;
    ctrl1.emit      = emit1;
    ctrl1.border    = border1;
    ctrl1.frame_end = frame_end1;
  end

  // Next values of the stream position state.
  always_comb begin
    wp_next      = wp;
    ep_next      = ep;
    pending_next = pending;
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;

    if (wr_en) begin
      wp_next = (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);
      if (in_col_p1 >= eff_w) begin
        in_col_next = '0;
        in_row_next = (in_row_p1 >= {1'b0, eff_h}) ? '0 : in_row_p1[RW-1:0];
      end else begin
        in_col_next = in_col_p1[CW-1:0];
      end
    end

    if (emit1) begin
      ep_next = (ep == AW'(RING - 1)) ? '0 : ep + AW'(1);
      if (out_col_p1 >= eff_w) begin
        out_col_next = '0;
        out_row_next = (out_row_p1 >= {1'b0, eff_h}) ? '0 : out_row_p1[RW-1:0];
      end else begin
        out_col_next = out_col_p1[CW-1:0];
      end
    end

    pending_next = pending + PW'(wr_en) - PW'(emit1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      ep      <= '0;
      pending <= '0;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      wp      <= wp_next;
      ep      <= ep_next;
      pending <= pending_next;
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Lane j of every row keeps the history shifted by j entries, so one read
  // per RAM returns WINDOW neighboring pixels of a row.
  for (genvar j = 0; j < WINDOW; j++) begin : g_waddr
    localparam int RJ = RING - j;
    logic [AW:0] wrap_sum;
    assign wrap_sum      = {1'b0, wp} + (AW + 1)'(RJ);
    assign lane_waddr[j] = (wp >= AW'(j)) ? (wp - AW'(j)) : wrap_sum[AW-1:0];
  end

  // Start of each window row in the history ring: output position plus the
  // row offset, minus RADIUS, wrapped once either way.
  for (genvar g = 0; g < WINDOW; g++) begin : g_row
    localparam int DR = g - RADIUS;
    logic signed [SW-1:0] row_sum;
    logic signed [SW-1:0] row_adj;

    always_comb begin
      row_sum = $signed({2'b00, ep})
              + SW'(DR) * $signed({{(SW - WW){1'b0}}, eff_w})
              - SW'(RADIUS);
      if (row_sum < 0) begin
        row_adj = row_sum + SW'(RING);
      end else if (row_sum >= SW'(RING)) begin
        row_adj = row_sum - SW'(RING);
      end else begin
        row_adj = row_sum;
      end
    end

    assign row_addr[g] = row_adj[AW-1:0];

    for (genvar j = 0; j < WINDOW; j++) begin : g_lane
      smf_ram #(
        .WIDTH(smf_pkg::PIX_W),
        .DEPTH(RING)
      ) u_hist (
        .clk  (clk),
        .we   (wr_en),
        .waddr(lane_waddr[j]),
        .wdata(item1.pixel_in),
        .raddr(row_addr[g]),
        .rdata(ram_q[g*WINDOW + j])
      );

      // The pixel written this cycle is not yet visible to the read.
      assign hit_c[g*WINDOW + j] = wr_en && (lane_waddr[j] == row_addr[g]);
    end
  end

  // Stage 2 registers alongside the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl2 <= '0;
    end else begin
      ctrl2 <= ctrl1;
    end
    byp_hit <= hit_c;
    byp_pix <= item1.pixel_in;
  end

  for (genvar m = 0; m < TAPS; m++) begin : g_tap
    assign taps2[m] = byp_hit[m] ? byp_pix : ram_q[m];
  end

  smf_median #(
    .WINDOW(WINDOW)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (ctrl2),
    .taps      (taps2),
    .ctrl_out  (med_ctrl),
    .median_pix(med_pix)
  );

  // Output queue. The credit count covers every item in the pipeline and every
  // queued result, so the queue cannot overflow.
  assign push = med_ctrl.valid && med_ctrl.emit;
  assign drop = med_ctrl.valid && !med_ctrl.emit;
  assign pop  = result_valid && !result_stall;

  always_comb begin
    fifo_cnt_next = fifo_cnt + smf_pkg::FIFO_CNT_W'(push) - smf_pkg::FIFO_CNT_W'(pop);
    credit_next   = credit + smf_pkg::FIFO_CNT_W'(accept)
                  - smf_pkg::FIFO_CNT_W'(drop) - smf_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      credit   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + smf_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + smf_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt_next;
      credit   <= credit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{pixel_out: med_pix, frame_end: med_ctrl.frame_end};
    end
  end

  assign result_valid = (fifo_cnt != '0);
  assign result       = fifo_mem[rd_ptr];

endmodule

@@ rtl/smf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for every copy of the pixel history. Depends on nothing else.
module smf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a read of the same address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/smf_median.sv @@
// Two-stage rank selector: picks the median of a WINDOW x WINDOW window,
// or the center pixel for border positions. Uses smf_pkg for the control struct.
module smf_median #(
  parameter int WINDOW = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smf_pkg::smf_ctrl_t       ctrl_in,
  input  logic [smf_pkg::PIX_W-1:0] taps [WINDOW*WINDOW],
  output smf_pkg::smf_ctrl_t       ctrl_out,
  output logic [smf_pkg::PIX_W-1:0] median_pix
);

  localparam int TAPS = WINDOW * WINDOW;
  localparam int MID  = TAPS / 2;

  logic [TAPS-1:0]           below [TAPS];
  logic [TAPS-1:0]           below_a [TAPS];
  logic [smf_pkg::PIX_W-1:0] vals_a [TAPS];
  smf_pkg::smf_ctrl_t        ctrl_a;
  logic [TAPS-1:0]           sel_b;
  logic [smf_pkg::PIX_W-1:0] vals_b [TAPS];
  smf_pkg::smf_ctrl_t        ctrl_b;
  logic [smf_pkg::PIX_W-1:0] pick;

  // Pairwise comparisons. Equal values are ordered by tap position, so every
  // tap gets a distinct rank.
  for (genvar i = 0; i < TAPS; i++) begin : g_cmp_i
    for (genvar k = 0; k < TAPS; k++) begin : g_cmp_k
      if (k == i) begin : g_self
        assign below[i][k] = 1'b0;
      end else if (k < i) begin : g_lower
        assign below[i][k] = (taps[k] <= taps[i]);
      end else begin : g_upper
        assign below[i][k] = (taps[k] < taps[i]);
      end
    end
  end

  // Stage A registers the comparison matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a <= '0;
    end else begin
      ctrl_a <= ctrl_in;
    end
    below_a <= below;
    vals_a  <= taps;
  end

  // Stage B registers a one-hot flag on the tap whose rank is the middle one.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_b <= '0;
    end else begin
      ctrl_b <= ctrl_a;
    end
    for (int i = 0; i < TAPS; i++) begin
      sel_b[i] <= ($countones(below_a[i]) == MID);
    end
    vals_b <= vals_a;
  end

  // Select the median, or pass the center tap through at the border.
  always_comb begin
    pick = '0;
    for (int i = 0; i < TAPS; i++) begin
      pick = pick | (vals_b[i] & {smf_pkg::PIX_W{sel_b[i]}});
    end
    median_pix = ctrl_b.border ? vals_b[MID] : pick;
  end

  assign ctrl_out = ctrl_b;

endmodule
